// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bodg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bodg_pkg
// Types and constants of the band onset detector with beat grouping.
// ----------------------------------------------------------------------------
package bodg_pkg;

  localparam int unsigned NumBands = 32;
  localparam int unsigned BandAw   = (NumBands > 1) ? $clog2(NumBands) : 1;

  // result queue
  localparam int unsigned OutDepth = 2;
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);
  localparam int unsigned OutPtrW  = (OutDepth > 1) ? $clog2(OutDepth) : 1;

  // request codes
  localparam logic ReqSample = 1'b0;
  localparam logic ReqFlush  = 1'b1;

  // register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgDecay     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgResetRate = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinGap    = 2'd2;

  // register reset values: decay 0.97 in Q0.16, rate 1.5 in Q8.8
  localparam logic [15:0] DecayRst     = 16'd63570;
  localparam logic [15:0] ResetRateRst = 16'd384;
  localparam logic [7:0]  MinGapRst    = 8'd1;

  localparam logic [47:0] SumMax = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic               req_type;
    logic [4:0]         band_index;
    logic signed [31:0] sample;
    logic               last_band;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] group_value;
    logic [31:0]        group_frame;
    logic               empty_marker;
  } out_item_t;

endpackage

// ===== rtl/core/bodg_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bodg_out_fifo
// Small result queue that parts the processing stage from the output stall.
// ----------------------------------------------------------------------------
module bodg_out_fifo import bodg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  out_item_t          push_item_i,
  input  logic               pop_i,
  output logic               valid_o,
  output out_item_t          item_o,
  output logic [OutCntW-1:0] count_o
);

  out_item_t            mem_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0]   cnt_q, cnt_d;
  logic                 do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == OutDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == OutDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + OutCntW'(push_i) - OutCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/band_onset_detect_group.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_onset_detect_group
// Per-band decaying-threshold onset detector that merges beats into groups.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One item per cycle sustained while the output is not stalled. A result item
//  is computed in the update stage from its registered input item and written
//  into the result queue, from which it is offered. The rate is set by the
//  threshold read-modify-write: a registered read of the threshold memory,
//  then compare, update and write back, with the value just written forwarded
//  to an item of the same band in the next cycle.
//  Reset and flush clear the thresholds at once through per-band valid bits;
//  there is no clearing pass. A two-entry result queue holds results under
//  output stall; input stalls only when that queue could overflow.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module band_onset_detect_group import bodg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] decay_q;
  logic [15:0] rate_q;
  logic [7:0]  min_gap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q   <= DecayRst;
      rate_q    <= ResetRateRst;
      min_gap_q <= MinGapRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgDecay:     decay_q   <= cfg_data_i;
        CfgResetRate: rate_q    <= cfg_data_i;
        CfgMinGap:    min_gap_q <= cfg_data_i[7:0];
        default:      ; // writes beyond the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and result queue
  // --------------------------------------------------------------------------
  logic               in_acc;
  logic               out_pop;
  logic [OutCntW-1:0] q_cnt;
  logic [OutCntW:0]   q_occ;
  logic               push;
  out_item_t          push_item;

  logic               s1_vld_q;
  in_item_t           s1_item_q;

  assign out_pop = out_valid_o && !out_stall_i;
  // Worst case every item in flight yields one result: keep room for all.
  assign q_occ      = (OutCntW + 1)'(q_cnt) + (OutCntW + 1)'(s1_vld_q)
                      - (OutCntW + 1)'(out_pop);
  assign in_stall_o = (32'(q_occ) >= OutDepth);
  assign in_acc     = in_valid_i && !in_stall_o;

  bodg_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (out_pop),
    .valid_o     (out_valid_o),
    .item_o      (out_item_o),
    .count_o     (q_cnt)
  );

  // --------------------------------------------------------------------------
  // Threshold memory: read on acceptance, written back from the update stage
  // --------------------------------------------------------------------------
  logic [31:0]         thr_mem [NumBands];
  logic [31:0]         thr_rdata_q;
  logic [NumBands-1:0] thr_vld_q;
  logic                fwd_q;
  logic [31:0]         fwd_data_q;

  logic [BandAw-1:0]   in_addr;
  logic [BandAw-1:0]   s1_addr;
  logic                thr_we;
  logic [31:0]         thr_new;
  logic                thr_clr;

  assign in_addr = BandAw'(in_item_i.band_index);
  assign s1_addr = BandAw'(s1_item_q.band_index);

  always_ff @(posedge clk_i) begin
    if (thr_we) begin
      thr_mem[s1_addr] <= thr_new;
    end
    if (in_acc) begin
      thr_rdata_q <= thr_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_vld_q <= '0;
      fwd_q     <= 1'b0;
      s1_vld_q  <= 1'b0;
    end else begin
      if (thr_clr) begin
        thr_vld_q <= '0;
      end else if (thr_we) begin
        thr_vld_q[s1_addr] <= 1'b1;
      end
      // forward the write-back when the next item reads the same band
      fwd_q    <= in_acc && thr_we && (in_addr == s1_addr);
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= thr_new;
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
  end

  // --------------------------------------------------------------------------
  // Update stage: beat test, threshold update, grouping
  // --------------------------------------------------------------------------
  logic [31:0] frame_q, frame_d;
  logic        open_q, open_d;
  logic [31:0] start_q, start_d;
  logic [31:0] last_q, last_d;
  logic [47:0] sum_q, sum_d;

  logic        is_flush;
  logic        band_ok;
  logic [31:0] thr_cur;
  logic        pos;
  logic        beat;
  logic [47:0] dec_prod;
  logic [31:0] decayed;
  logic [46:0] raise_prod;
  logic [31:0] raised;
  logic [31:0] gap;
  logic        split;
  logic [48:0] sum_add;
  logic [47:0] sum_sat;
  logic [47:0] smp_ext;

  assign is_flush = (s1_item_q.req_type == ReqFlush);
  assign band_ok  = (32'(s1_item_q.band_index) < NumBands);
  assign thr_cur  = fwd_q ? fwd_data_q : (thr_vld_q[s1_addr] ? thr_rdata_q : '0);

  // thresholds are never negative, so only positive samples can beat
  assign pos  = !s1_item_q.sample[31];
  assign beat = pos && ({1'b0, s1_item_q.sample[30:0]} > thr_cur);

  assign dec_prod   = 48'(thr_cur) * 48'(decay_q);
  assign decayed    = dec_prod[47:16];
  assign raise_prod = 47'(s1_item_q.sample[30:0]) * 47'(rate_q);
  assign raised     = !pos ? '0 : ((|raise_prod[46:40]) ? '1 : raise_prod[39:8]);
  assign thr_new    = (decayed > raised) ? decayed : raised;

  assign thr_we  = s1_vld_q && !is_flush && band_ok;
  assign thr_clr = s1_vld_q && is_flush;

  assign gap     = frame_q - last_q;
  assign split   = open_q && (gap > 32'(min_gap_q));
  assign smp_ext = 48'(s1_item_q.sample[30:0]);
  assign sum_add = 49'(sum_q) + 49'(smp_ext);
  assign sum_sat = (sum_add > 49'(SumMax)) ? SumMax : sum_add[47:0];

  always_comb begin
    frame_d = frame_q;
    open_d  = open_q;
    start_d = start_q;
    last_d  = last_q;
    sum_d   = sum_q;
    push    = 1'b0;
    push_item.group_value  = sum_q;
    push_item.group_frame  = start_q;
    push_item.empty_marker = 1'b0;

    if (s1_vld_q) begin
      if (is_flush) begin
        // emit the open group or a zero record, then drop all state
        push = 1'b1;
        if (!open_q) begin
          push_item.group_value  = '0;
          push_item.group_frame  = '0;
          push_item.empty_marker = 1'b1;
        end
        frame_d = '0;
        open_d  = 1'b0;
        start_d = '0;
        last_d  = '0;
        sum_d   = '0;
      end else begin
        if (band_ok && beat) begin
          // a beat past the gap closes the open group and starts a new one
          push   = split;
          open_d = 1'b1;
          last_d = frame_q;
          if (!open_q || split) begin
            start_d = frame_q;
            sum_d   = smp_ext;
          end else begin
            sum_d = sum_sat;
          end
        end
        if (s1_item_q.last_band) begin
          frame_d = frame_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      open_q  <= 1'b0;
      start_q <= '0;
      last_q  <= '0;
      sum_q   <= '0;
    end else begin
      frame_q <= frame_d;
      open_q  <= open_d;
      start_q <= start_d;
      last_q  <= last_d;
      sum_q   <= sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_queue_room, (32'(q_cnt) + 32'(s1_vld_q)) <= OutDepth, "result queue overrun")
  `ASSERT_NEXT(a_flush_clears, thr_clr, (thr_vld_q == '0) && !open_q && (frame_q == '0), "flush left state behind")
  `ASSERT_ALWAYS(a_sum_bound, sum_q <= SumMax, "group sum above saturation limit")

endmodule
